// File: design/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types and constants of the PIR motion qualifier: register indexes,
// item kinds, timing and scoring constants and the packed result layout.
// ----------------------------------------------------------------------------
package pmq_pkg;

	localparam int TIME_W  = 32;
	localparam int HITS_W  = 16;
	localparam int CONF_W  = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 96;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_ENABLE     = 3'd0,
		REG_HOLDOFF_TIME     = 3'd1,
		REG_MOTION_TIMEOUT   = 3'd2,
		REG_MIN_HITS         = 3'd3,
		REG_WILDLIFE_DUR     = 3'd4,
		REG_CONF_THRESHOLD   = 3'd5,
		REG_WIND_FILTER      = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		OP_EDGE = 1'b0,
		OP_POLL = 1'b1
	} op_t;

	// timing constants in milliseconds and hit-count thresholds
	localparam logic [TIME_W-1:0] DEBOUNCE_MS   = 32'd50;
	localparam logic [TIME_W-1:0] MIN_DUR_MS    = 32'd500;
	localparam logic [TIME_W-1:0] MAX_DUR_MS    = 32'd30000;
	localparam logic [TIME_W-1:0] WIND_DUR_MS   = 32'd1000;
	localparam logic [HITS_W-1:0] WIND_HITS     = 16'd3;
	localparam logic [HITS_W-1:0] BURST_HITS    = 16'd10;
	localparam logic [HITS_W-1:0] HITS_MAX      = 16'hFFFF;

	// confidence scoring
	localparam logic [CONF_W-1:0] CONF_BASE     = 7'd50;
	localparam logic [CONF_W-1:0] CONF_DUR_BON  = 7'd20;
	localparam logic [CONF_W-1:0] CONF_HIT_BON  = 7'd15;
	localparam logic [CONF_W-1:0] CONF_PAT_BON  = 7'd15;
	localparam logic [CONF_W-1:0] CONF_MAX      = 7'd100;

	// register reset values
	localparam logic [15:0] HOLDOFF_RST   = 16'd100;
	localparam logic [15:0] TIMEOUT_RST   = 16'd5000;
	localparam logic [7:0]  MIN_HITS_RST  = 8'd3;
	localparam logic [15:0] WILD_DUR_RST  = 16'd2000;
	localparam logic [6:0]  CONF_THR_RST  = 7'd70;

	// first member is the most significant, so motion_active lands in bit 0
	typedef struct packed {
		logic [TIME_W-1:0] event_total;
		logic              trigger_recording;
		logic [CONF_W-1:0] confidence;
		logic              wildlife_motion;
		logic [HITS_W-1:0] hit_count;
		logic [TIME_W-1:0] duration_ms;
		logic              motion_started;
		logic              motion_active;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

// File: design/pir_motion_qualifier_top.sv
// ----------------------------------------------------------------------------
// pir_motion_qualifier_top
// Debounces sensor edges, tracks motion across polls and scores each poll
// for wildlife classification and recording trigger.
// ----------------------------------------------------------------------------
// result path: an accepted poll passes the input stage, then the result
//   register; edge items give no result
// throughput: one item per cycle while polls find room in the result
//   register, set by the state update in the input stage feeding itself
// reset: arst_n clears all motion state and loads register defaults
// ----------------------------------------------------------------------------
module pir_motion_qualifier_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pmq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pmq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pmq_pkg::S_TDATA_W-1:0]    s_tdata,  // now_ms[31:0], pin_level[32]
	input  logic                             s_tuser,  // opcode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// motion_active[0], motion_started[1], duration_ms[33:2], hit_count[49:34],
	// wildlife_motion[50], confidence[57:51], trigger_recording[58],
	// event_total[90:59]
	output logic [pmq_pkg::M_TDATA_W-1:0]    m_tdata
);
	import pmq_pkg::*;

	// configuration
	logic              enable_q;
	logic [15:0]       holdoff_q;
	logic [15:0]       timeout_q;
	logic [7:0]        min_hits_q;
	logic [15:0]       wild_dur_q;
	logic [6:0]        conf_thr_q;
	logic              wind_en_q;

	// input stage
	logic              v_s1;
	op_t               op_s1;
	logic [TIME_W-1:0] now_s1;
	logic              pin_s1;

	// motion state
	logic              active_q, active_d;
	logic              latch_q, latch_d;
	logic [TIME_W-1:0] last_edge_q, last_edge_d;
	logic [TIME_W-1:0] start_q, start_d;
	logic [TIME_W-1:0] seen_q, seen_d;
	logic [HITS_W-1:0] hits_q, hits_d;
	logic [TIME_W-1:0] total_q, total_d;

	// output stage
	logic              m_valid_q;
	result_t           res_q;
	result_t           res_d;

	logic              consume;
	logic              started;
	logic              present;
	logic              in_run;
	logic              timed_out;
	logic [TIME_W-1:0] since_edge;
	logic [TIME_W-1:0] since_seen;
	logic [TIME_W-1:0] dur;
	logic [HITS_W-1:0] min_hits_x;
	logic              valid_pat;
	logic              wild;
	logic [CONF_W-1:0] conf;

	// an edge leaves the stage at once, a poll needs room in the result register
	assign consume  = v_s1 && (op_s1 == OP_EDGE || !m_valid_q || m_tready);
	assign s_tready = !v_s1 || consume;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_TDATA_W-RESULT_W){1'b0}}, res_q};

	assign min_hits_x = {{(HITS_W-8){1'b0}}, min_hits_q};
	assign present    = pin_s1 || latch_q;
	assign in_run     = now_s1 >= {{(TIME_W-16){1'b0}}, holdoff_q};
	assign since_edge = now_s1 - last_edge_q;
	assign since_seen = now_s1 - seen_q;
	assign timed_out  = since_seen > {{(TIME_W-16){1'b0}}, timeout_q};

	always_comb begin
		active_d    = active_q;
		latch_d     = latch_q;
		last_edge_d = last_edge_q;
		start_d     = start_q;
		seen_d      = seen_q;
		hits_d      = hits_q;
		total_d     = total_q;
		started     = 1'b0;
		if (op_s1 == OP_EDGE) begin
			if (enable_q && since_edge > DEBOUNCE_MS) begin
				latch_d     = 1'b1;
				last_edge_d = now_s1;
			end
		end else if (enable_q) begin
			latch_d = 1'b0;
			if (in_run) begin
				if (present && !active_q) begin
					active_d = 1'b1;
					start_d  = now_s1;
					seen_d   = now_s1;
					hits_d   = 16'd1;
					total_d  = total_q + 32'd1;
					started  = 1'b1;
				end else if (present) begin
					seen_d = now_s1;
					if (hits_q != HITS_MAX) begin
						hits_d = hits_q + 16'd1;
					end
				end else if (active_q && timed_out) begin
					active_d = 1'b0;
				end
			end
		end
	end

	// scoring works on the state as left by this poll
	always_comb begin
		dur = (active_d && !started) ? now_s1 - start_q : '0;
		valid_pat = dur >= {{(TIME_W-16){1'b0}}, wild_dur_q} && hits_d >= min_hits_x &&
			dur <= MAX_DUR_MS && !(dur < MIN_DUR_MS && hits_d > BURST_HITS);
		wild = active_d && dur >= MIN_DUR_MS && dur <= MAX_DUR_MS &&
			hits_d >= min_hits_x && valid_pat &&
			!(wind_en_q && dur < WIND_DUR_MS && hits_d < WIND_HITS);
		conf = CONF_BASE;
		if (dur > {{(TIME_W-16){1'b0}}, wild_dur_q}) conf = conf + CONF_DUR_BON;
		if (hits_d > min_hits_x) conf = conf + CONF_HIT_BON;
		if (valid_pat) conf = conf + CONF_PAT_BON;
		if (conf > CONF_MAX) conf = CONF_MAX;

		res_d = '0;
		res_d.event_total = total_d;
		if (enable_q) begin
			res_d.motion_active     = active_d;
			res_d.motion_started    = started;
			res_d.duration_ms       = dur;
			res_d.hit_count         = hits_d;
			res_d.wildlife_motion   = wild;
			res_d.confidence        = conf;
			res_d.trigger_recording = wild && conf >= conf_thr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			holdoff_q  <= HOLDOFF_RST;
			timeout_q  <= TIMEOUT_RST;
			min_hits_q <= MIN_HITS_RST;
			wild_dur_q <= WILD_DUR_RST;
			conf_thr_q <= CONF_THR_RST;
			wind_en_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BLOCK_ENABLE:   enable_q   <= cfg_wdata[0];
				REG_HOLDOFF_TIME:   holdoff_q  <= cfg_wdata;
				REG_MOTION_TIMEOUT: timeout_q  <= cfg_wdata;
				REG_MIN_HITS:       min_hits_q <= cfg_wdata[7:0];
				REG_WILDLIFE_DUR:   wild_dur_q <= cfg_wdata;
				REG_CONF_THRESHOLD: conf_thr_q <= cfg_wdata[6:0];
				REG_WIND_FILTER:    wind_en_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= op_t'(s_tuser);
			now_s1 <= s_tdata[TIME_W-1:0];
			pin_s1 <= s_tdata[TIME_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			latch_q     <= 1'b0;
			last_edge_q <= '0;
			start_q     <= '0;
			seen_q      <= '0;
			hits_q      <= '0;
			total_q     <= '0;
		end else if (consume) begin
			active_q    <= active_d;
			latch_q     <= latch_d;
			last_edge_q <= last_edge_d;
			start_q     <= start_d;
			seen_q      <= seen_d;
			hits_q      <= hits_d;
			total_q     <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (consume && op_s1 == OP_POLL) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && op_s1 == OP_POLL) begin
			res_q <= res_d;
		end
	end

	// a fresh start has one hit and no elapsed time
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.motion_started |->
			res_q.motion_active && res_q.hit_count == 16'd1 && res_q.duration_ms == '0)
		else $error("started item without a clean motion start");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.trigger_recording |->
			res_q.wildlife_motion && res_q.motion_active &&
			res_q.confidence >= conf_thr_q)
		else $error("recording trigger without qualified wildlife motion");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_q.confidence <= CONF_MAX &&
			(res_q.confidence >= CONF_BASE || !res_q.motion_active))
		else $error("confidence out of range");

	// an edge never changes the motion counters
	assert property (@(posedge clk) disable iff (!arst_n)
		consume && op_s1 == OP_EDGE |=> $stable(total_q) && $stable(hits_q))
		else $error("edge item changed motion counters");

endmodule
